// ===== rtl/stb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types, constants and the duration saturation function for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int unsigned ACTION_W   = 4;
   localparam int unsigned ID_W       = 3;
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned PERIOD_W   = 6;
   localparam int unsigned MAX_PERIOD = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK       = 4'd0,
      ACT_ONESHOT    = 4'd1,
      ACT_REPEAT     = 4'd2,
      ACT_POLL       = 4'd3,
      ACT_WATCH_SET  = 4'd4,
      ACT_WATCH_READ = 4'd5,
      ACT_SPLIT      = 4'd6,
      ACT_STOP       = 4'd7,
      ACT_CLOCK      = 4'd8
   } action_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;   // latch request, launch entry read
      logic execute;   // apply the action, register the result
   } cmd_type;

   function automatic logic [PERIOD_W-1:0] sat_duration(input logic [TIME_W-1:0] dur);
      logic [PERIOD_W-1:0] res;
      if (dur > TIME_W'(MAX_PERIOD)) begin
         res = PERIOD_W'(MAX_PERIOD);
      end else begin
         res = dur[PERIOD_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/stb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/stb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ctrl
// Two-state controller: accept a request, then execute it and strobe result.
// ----------------------------------------------------------------------------
module stb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output stb_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in    = state_ff;
      strobe_in   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            strobe_in   = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = strobe_ff;

endmodule

// ===== rtl/stb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_datapath
// Clock counter, per-timer flags, trigger/period RAM and result registers.
// ----------------------------------------------------------------------------
module stb_datapath #(
   parameter int unsigned NUM_TIMERS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stb_pkg::cmd_type                      cmd,
   input  logic [stb_pkg::ACTION_W-1:0]          req_action,
   input  logic [stb_pkg::ID_W-1:0]              req_timer_id,
   input  logic [stb_pkg::TIME_W-1:0]            req_duration,
   output logic                                  rsp_tripped,
   output logic [stb_pkg::TIME_W-1:0]            rsp_value
);

   localparam int unsigned IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int unsigned ENTRY_W = stb_pkg::TIME_W + stb_pkg::PERIOD_W;

   // request captured at transfer
   logic [stb_pkg::ACTION_W-1:0] action_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic                         ok_ff;
   logic [stb_pkg::TIME_W-1:0]   duration_ff;

   logic [stb_pkg::TIME_W-1:0]   clock_ms_ff, clock_ms_in;
   logic [NUM_TIMERS-1:0]        armed_ff, armed_in;
   logic [NUM_TIMERS-1:0]        watch_ff, watch_in;
   logic                         tripped_ff, tripped_in;
   logic [stb_pkg::TIME_W-1:0]   value_ff, value_in;

   logic                         mem_we;
   logic [ENTRY_W-1:0]           mem_wdata;
   logic [ENTRY_W-1:0]           mem_rdata;
   logic [stb_pkg::TIME_W-1:0]   trig_rd;
   logic [stb_pkg::PERIOD_W-1:0] per_rd;
   logic [stb_pkg::TIME_W-1:0]   diff;
   logic [stb_pkg::PERIOD_W-1:0] dur_sat;

   stb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx_ff),
      .wr_data (mem_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (IDX_W'(req_timer_id)),
      .rd_data (mem_rdata)
   );

   assign trig_rd = mem_rdata[ENTRY_W-1 -: stb_pkg::TIME_W];
   assign per_rd  = mem_rdata[stb_pkg::PERIOD_W-1:0];
   assign diff    = clock_ms_ff - trig_rd;
   assign dur_sat = stb_pkg::sat_duration(duration_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= req_action;
         idx_ff      <= IDX_W'(req_timer_id);
         ok_ff       <= (int'(req_timer_id) < NUM_TIMERS);
         duration_ff <= req_duration;
      end
      if (cmd.execute) begin
         tripped_ff <= tripped_in;
         value_ff   <= value_in;
      end
   end

   always_comb begin
      clock_ms_in = clock_ms_ff;
      armed_in    = armed_ff;
      watch_in    = watch_ff;
      mem_we      = 1'b0;
      mem_wdata   = mem_rdata;
      tripped_in  = 1'b0;
      value_in    = '0;
      if (cmd.execute) begin
         unique case (stb_pkg::action_type'(action_ff))
            stb_pkg::ACT_TICK: begin
               clock_ms_in = clock_ms_ff + 1'b1;
            end
            stb_pkg::ACT_CLOCK: begin
               value_in = clock_ms_ff;
            end
            stb_pkg::ACT_ONESHOT, stb_pkg::ACT_REPEAT: begin
               if (ok_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = {clock_ms_ff + stb_pkg::TIME_W'(dur_sat),
                               (action_ff == stb_pkg::ACT_REPEAT) ? dur_sat
                                                                  : stb_pkg::PERIOD_W'(0)};
                  watch_in[idx_ff] = 1'b0;
                  armed_in[idx_ff] = 1'b1;
               end
            end
            stb_pkg::ACT_POLL: begin
               // expired when clock - trigger is non-negative as a signed value
               if (ok_ff && armed_ff[idx_ff] && !diff[stb_pkg::TIME_W-1]) begin
                  tripped_in = 1'b1;
                  if (per_rd != '0) begin
                     mem_we    = 1'b1;
                     mem_wdata = {trig_rd + stb_pkg::TIME_W'(per_rd), per_rd};
                  end else begin
                     armed_in[idx_ff] = 1'b0;
                  end
               end
            end
            stb_pkg::ACT_WATCH_SET: begin
               if (ok_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = {clock_ms_ff, per_rd};
                  watch_in[idx_ff] = 1'b1;
                  armed_in[idx_ff] = 1'b0;
               end
            end
            stb_pkg::ACT_WATCH_READ: begin
               if (ok_ff && watch_ff[idx_ff]) begin
                  value_in = diff;
               end
            end
            stb_pkg::ACT_SPLIT: begin
               if (ok_ff && watch_ff[idx_ff]) begin
                  value_in  = diff;
                  mem_we    = 1'b1;
                  mem_wdata = {clock_ms_ff, per_rd};
               end
            end
            stb_pkg::ACT_STOP: begin
               if (ok_ff) begin
                  armed_in[idx_ff] = 1'b0;
                  watch_in[idx_ff] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff <= '0;
         armed_ff    <= '0;
         watch_ff    <= '0;
      end else begin
         clock_ms_ff <= clock_ms_in;
         armed_ff    <= armed_in;
         watch_ff    <= watch_in;
      end
   end

   assign rsp_tripped = tripped_ff;
   assign rsp_value   = value_ff;

endmodule

// ===== rtl/soft_timer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_timer_bank
// Millisecond clock and a bank of one-shot/repeating timers and stopwatches.
// ----------------------------------------------------------------------------
// Result: the result strobe rsp_valid is registered and follows the request
//   transfer after the entry RAM read and then the execute state.
// Requests: a new request is not taken before the last one is through; busy
//   covers the execute cycle that follows the registered read of the timer's entry RAM.
// Reset: synchronous; clears the clock, all armed and stopwatch flags and the
//   controller. Entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
module soft_timer_bank #(
   parameter int unsigned NUM_TIMERS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [stb_pkg::ACTION_W-1:0]      req_action,
   input  logic [stb_pkg::ID_W-1:0]          req_timer_id,
   input  logic [stb_pkg::TIME_W-1:0]        req_duration,
   output logic                              rsp_valid,
   output logic                              rsp_tripped,
   output logic [stb_pkg::TIME_W-1:0]        rsp_value
);

   stb_pkg::cmd_type cmd;

   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   stb_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_action   (req_action),
      .req_timer_id (req_timer_id),
      .req_duration (req_duration),
      .rsp_tripped  (rsp_tripped),
      .rsp_value    (rsp_value)
   );

   // a transfer always leads into the execute state
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer did not enter execute");

   assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("execute did not end with a result strobe");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still executing");

   // only a poll can trip, and tripped never comes with a value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tripped) |-> (rsp_value == '0))
      else $error("tripped result carries a value");

endmodule
